[rtl/fsa_pkg.sv]
// Shared types for the free-list slot allocator.
// No dependencies; imported by the top level.
`default_nettype none

package fsa_pkg;

	localparam int unsigned SLOT_FIELD_W = 8;
	localparam int unsigned STATUS_W     = 2;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_ALLOC = 2'd2
	} fsa_status_t;

	typedef enum logic {
		ACT_ALLOC = 1'b0,
		ACT_FREE  = 1'b1
	} fsa_action_t;

endpackage

`default_nettype wire

[rtl/fsa_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
// Standalone; used by the allocator for the link and allocated-mark stores.
`default_nettype none

module fsa_ram #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned WIDTH = 9
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/free_list_slot_allocator.sv]
// Top level of the free-list slot allocator: head, fresh watermark, result register.
// Depends on fsa_pkg and fsa_ram.
//
//  channel | signals                              | flow
//  --------+--------------------------------------+---------------------------
//  request | in_valid, in_stall, action,          | into block, one beat per
//          | slot_to_free                         | request
//  result  | out_valid, out_stall, granted_slot,  | out of block, one beat per
//          | status                               | request
//
// Each request has an accept step that reads the link or mark RAM through its
// registered read port, and a retire step that updates head and writes back.
// One request is in flight at a time; a result waiting in the output register
// does not block the next request until the following one must retire.
// Reset needs no clearing pass: slots at or above the fresh watermark were
// never handed out, so their link is implied as index+1 and their mark as clear.
`default_nettype none

module free_list_slot_allocator #(
	parameter int unsigned SLOTS = 256
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output      logic                              in_stall,
	input  wire logic                              action,
	input  wire logic [fsa_pkg::SLOT_FIELD_W-1:0]  slot_to_free,
	output      logic                              out_valid,
	input  wire logic                              out_stall,
	output      logic [fsa_pkg::SLOT_FIELD_W-1:0]  granted_slot,
	output      logic [fsa_pkg::STATUS_W-1:0]      status
);

	import fsa_pkg::*;

	localparam int unsigned IDXW  = $clog2(SLOTS);
	localparam int unsigned LINKW = $clog2(SLOTS + 1);
	localparam int unsigned CMPW  = (LINKW > SLOT_FIELD_W) ? LINKW : SLOT_FIELD_W;
	localparam logic [LINKW-1:0] NULL_LINK = LINKW'(SLOTS);

	logic                    busy_s1;
	logic                    action_s1;
	logic [SLOT_FIELD_W-1:0] idx_s1;

	logic [LINKW-1:0] head_q;
	logic [LINKW-1:0] fresh_q;

	logic                    out_valid_q;
	logic [SLOT_FIELD_W-1:0] granted_q;
	fsa_status_t             status_q;

	logic             accept;
	logic             retire;
	logic [IDXW-1:0]  rd_addr;
	logic [LINKW-1:0] link_rd;
	logic             mark_rd;

	logic             head_fresh;
	logic             pool_empty;
	logic             free_ok;
	logic [LINKW-1:0] next_head;

	logic             link_we;
	logic             mark_we;
	logic [IDXW-1:0]  wr_addr;
	logic             mark_wdata;

	assign in_stall = busy_s1;
	assign accept   = in_valid && !busy_s1;
	assign retire   = busy_s1 && (!out_valid_q || !out_stall);

	// Free reads the mark of the named slot, allocate reads the head's link.
	assign rd_addr = (action == ACT_FREE) ? IDXW'(slot_to_free) : head_q[IDXW-1:0];

	fsa_ram #(.DEPTH(SLOTS), .WIDTH(LINKW)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (wr_addr),
		.wdata (head_q),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (link_rd)
	);

	fsa_ram #(.DEPTH(SLOTS), .WIDTH(1)) u_mark_ram (
		.clk   (clk),
		.we    (mark_we),
		.waddr (wr_addr),
		.wdata (mark_wdata),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (mark_rd)
	);

	always_comb begin
		head_fresh = (head_q >= fresh_q);
		pool_empty = (head_q == NULL_LINK);
		// A slot below the watermark has had its mark written at least once.
		free_ok    = (CMPW'(idx_s1) < CMPW'(fresh_q)) && mark_rd;
		next_head  = head_fresh ? (head_q + LINKW'(1)) : link_rd;

		link_we    = 1'b0;
		mark_we    = 1'b0;
		mark_wdata = 1'b0;
		wr_addr    = head_q[IDXW-1:0];
		if (retire) begin
			if (action_s1 == ACT_FREE) begin
				wr_addr    = IDXW'(idx_s1);
				link_we    = free_ok;
				mark_we    = free_ok;
				mark_wdata = 1'b0;
			end else begin
				mark_we    = !pool_empty;
				mark_wdata = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else if (accept) begin
			busy_s1 <= 1'b1;
		end else if (retire) begin
			busy_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= action;
			idx_s1    <= slot_to_free;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			fresh_q <= '0;
		end else if (retire) begin
			if (action_s1 == ACT_FREE) begin
				if (free_ok) begin
					head_q <= LINKW'(idx_s1);
				end
			end else if (!pool_empty) begin
				head_q <= next_head;
				if (head_fresh) begin
					fresh_q <= fresh_q + LINKW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (retire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (retire) begin
			if (action_s1 == ACT_FREE) begin
				granted_q <= '0;
				status_q  <= free_ok ? ST_OK : ST_NOT_ALLOC;
			end else if (pool_empty) begin
				granted_q <= '0;
				status_q  <= ST_EMPTY;
			end else begin
				granted_q <= SLOT_FIELD_W'(head_q);
				status_q  <= ST_OK;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign granted_slot = granted_q;
	assign status       = status_q;

endmodule

`default_nettype wire

[sim/free_list_slot_allocator_tb.sv]
// Self-checking bench for the free-list slot allocator: directed and phased random requests,
// with a pool tracker class that predicts every grant. Depends on fsa_pkg and the RTL top.
`timescale 1ns / 100ps

module free_list_slot_allocator_tb;
	import fsa_pkg::*;

	localparam int POOL_SLOTS  = 256;
	localparam int RAND_ITEMS  = 2000;
	localparam int CALM_TAIL   = 300;
	localparam int MODE_FILL   = 0;
	localparam int MODE_DRAIN  = 1;
	localparam int MODE_MIXED  = 2;

	typedef struct {
		logic [SLOT_FIELD_W-1:0] granted;
		fsa_status_t             status;
	} grant_t;

	class slot_pool_tracker;
		logic [8:0]  link_of [0:POOL_SLOTS-1];
		bit          busy    [0:POOL_SLOTS-1];
		logic [8:0]  head;
		int          busy_total;
		int          mismatches;
		grant_t      pending_grants[$];

		function new();
			for (int i = 0; i < POOL_SLOTS; i++) begin
				link_of[i] = 9'(i + 1);
				busy[i] = 1'b0;
			end
			head = '0;
			busy_total = 0;
			mismatches = 0;
		endfunction

		function void fault(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%s", msg);
		endfunction

		// Advance the pool by one accepted request and queue its grant.
		function void note_request(fsa_action_t act, logic [SLOT_FIELD_W-1:0] slot);
			grant_t     g;
			logic [8:0] taken;
			g.granted = '0;
			g.status  = ST_OK;
			if (act == ACT_ALLOC) begin
				if (head >= 9'(POOL_SLOTS)) begin
					g.status = ST_EMPTY;
				end else begin
					taken = head;
					head = link_of[taken];
					busy[taken] = 1'b1;
					busy_total++;
					g.granted = taken[7:0];
				end
			end else begin
				if (!busy[slot]) begin
					g.status = ST_NOT_ALLOC;
				end else begin
					link_of[slot] = head;
					head = {1'b0, slot};
					busy[slot] = 1'b0;
					busy_total--;
				end
			end
			pending_grants.push_back(g);
		endfunction

		function void check_grant(logic [SLOT_FIELD_W-1:0] granted, logic [STATUS_W-1:0] status);
			grant_t g;
			if (pending_grants.size() == 0) begin
				fault($sformatf("unexpected result beat: granted_slot=%0d status=%0d",
					granted, status));
			end else begin
				g = pending_grants.pop_front();
				if (granted !== g.granted || status !== g.status)
					fault($sformatf("result mismatch: expected granted_slot=%0d status=%s, got granted_slot=%0d status=%0d",
						g.granted, g.status.name(), granted, status));
			end
		endfunction

		// Random allocated slot, or -1 when none is out.
		function int pick_busy();
			int start;
			if (busy_total == 0)
				return -1;
			start = $urandom_range(0, POOL_SLOTS - 1);
			for (int i = 0; i < POOL_SLOTS; i++)
				if (busy[(start + i) % POOL_SLOTS])
					return (start + i) % POOL_SLOTS;
			return -1;
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic                    action;
	logic [SLOT_FIELD_W-1:0] slot_to_free;
	logic                    out_valid;
	logic                    out_stall;
	logic [SLOT_FIELD_W-1:0] granted_slot;
	logic [STATUS_W-1:0]     status;

	slot_pool_tracker board = new();
	bit calm;

	free_list_slot_allocator #(
		.SLOTS(POOL_SLOTS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.slot_to_free(slot_to_free),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.granted_slot(granted_slot),
		.status(status)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("free_list_slot_allocator verification failed");
		$finish;
	end

	// Offer one request beat, hold it until taken, then log it.
	task automatic issue_request(fsa_action_t act, logic [SLOT_FIELD_W-1:0] slot);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		action       <= act;
		slot_to_free <= slot;
		do
			@(posedge clk);
		while (!(in_valid === 1'b1 && in_stall === 1'b0));
		board.note_request(act, slot);
	endtask

	task automatic run_phase(int mode, int len, int upto);
		int          i;
		int          pick;
		bit          want_alloc;
		logic [7:0]  slot;
		for (i = 0; i < len && board.mismatches >= 0; i++) begin
			if (upto - i <= CALM_TAIL)
				calm = 1'b1;
			case (mode)
				MODE_FILL:  want_alloc = ($urandom_range(0, 99) < 85);
				MODE_DRAIN: want_alloc = ($urandom_range(0, 99) < 15);
				default:    want_alloc = ($urandom_range(0, 1) == 0);
			endcase
			slot = 8'($urandom);
			if (want_alloc) begin
				issue_request(ACT_ALLOC, slot);
			end else begin
				pick = board.pick_busy();
				// Mostly free a slot that is out; sometimes a stray or repeated index.
				if (pick >= 0 && $urandom_range(0, 6) != 0)
					slot = 8'(pick);
				issue_request(ACT_FREE, slot);
			end
		end
	endtask

	initial begin
		int left;
		int len;
		int mode;
		int waited;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		action       = ACT_ALLOC;
		slot_to_free = '0;
		calm         = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: fresh grants, LIFO reuse, double free, stray frees, ignored index.
		issue_request(ACT_ALLOC, 8'hFF);
		issue_request(ACT_ALLOC, 8'h00);
		issue_request(ACT_FREE,  8'hFF);
		issue_request(ACT_FREE,  8'h00);
		issue_request(ACT_FREE,  8'h00);
		issue_request(ACT_ALLOC, 8'hAA);
		issue_request(ACT_FREE,  8'h01);
		issue_request(ACT_FREE,  8'h00);
		issue_request(ACT_ALLOC, 8'h55);
		issue_request(ACT_ALLOC, 8'h00);
		issue_request(ACT_ALLOC, 8'hFF);
		issue_request(ACT_FREE,  8'h80);
		issue_request(ACT_FREE,  8'h02);
		issue_request(ACT_FREE,  8'h01);
		issue_request(ACT_FREE,  8'h01);
		issue_request(ACT_ALLOC, 8'h7F);
		issue_request(ACT_ALLOC, 8'h00);
		issue_request(ACT_FREE,  8'h00);

		// Open with a long allocate-heavy fill phase to load the pool early.
		left = RAND_ITEMS;
		run_phase(MODE_FILL, 320, left);
		left -= 320;
		while (left > 0) begin
			mode = $urandom_range(MODE_FILL, MODE_MIXED);
			len  = $urandom_range(60, 300);
			if (len > left)
				len = left;
			if (left > CALM_TAIL)
				calm = ($urandom_range(0, 4) == 0);
			run_phase(mode, len, left);
			left -= len;
		end
		in_valid <= 1'b0;

		waited = 0;
		while (board.pending_grants.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		if (board.pending_grants.size() != 0)
			board.fault($sformatf("%0d expected results never arrived",
				board.pending_grants.size()));

		if (board.mismatches == 0)
			$display("free_list_slot_allocator verification clean");
		else
			$display("free_list_slot_allocator verification failed");
		$finish;
	end

	// Receiver side: stall in short bursts unless the run is in a calm stretch.
	initial begin
		int burst_left;
		out_stall  = 1'b0;
		burst_left = 0;
		forever begin
			@(posedge clk);
			if (burst_left > 0) begin
				burst_left--;
			end else if (!calm && arst_n && $urandom_range(0, 4) == 0) begin
				out_stall  <= 1'b1;
				burst_left = $urandom_range(1, 5) - 1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0)
			board.check_grant(granted_slot, status);
	end

endmodule
